// ----- rtl/mexp_pkg.sv -----
// shared types, constants and control codes of the modular exponentiation block
package mexp_pkg;

   localparam int VALUE_WIDTH     = 31;
   localparam int CNT_WIDTH       = $clog2(VALUE_WIDTH);
   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic [VALUE_WIDTH-1:0]     value_type;
   typedef logic [CNT_WIDTH-1:0]       count_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type REG_MODULUS   = csr_index_type'(0);
   localparam csr_index_type REG_GENERATOR = csr_index_type'(1);

   localparam value_type MODULUS_RESET   = value_type'(23);
   localparam value_type GENERATOR_RESET = value_type'(5);

   localparam logic CMD_PUBLIC = 1'b0;
   localparam logic CMD_SHARED = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_START,
      ST_RED_RUN,
      ST_RED_WB,
      ST_CHECK,
      ST_MUL_RUN,
      ST_MUL_WB,
      ST_SQR_RUN,
      ST_SQR_WB,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SRC_REDUCE,
      SRC_RESULT,
      SRC_SQUARE
   } mul_src_type;

   typedef enum logic [1:0] {
      WB_NONE,
      WB_BASE,
      WB_RESULT
   } wb_dest_type;

   typedef struct packed {
      logic        load;
      logic        mul_start;
      mul_src_type mul_src;
      logic        mul_step;
      wb_dest_type wb_dest;
      logic        exp_shift;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_last;
      logic exp_bit;
      logic exp_last;
   } dp_status_type;

endpackage

// ----- rtl/mexp_interfaces.sv -----
// request, response and register write channel interfaces

interface mexp_req_if;
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   mexp_pkg::value_type  peer_value;
   mexp_pkg::value_type  exponent;

   modport source (output valid, output cmd, output peer_value, output exponent, input ready);
   modport sink (input valid, input cmd, input peer_value, input exponent, output ready);
   modport monitor (input valid, input ready, input cmd, input peer_value, input exponent);
endinterface

interface mexp_rsp_if;
   logic                 valid;
   logic                 ready;
   mexp_pkg::value_type  key_value;

   modport source (output valid, output key_value, input ready);
   modport sink (input valid, input key_value, output ready);
   modport monitor (input valid, input ready, input key_value);
endinterface

interface mexp_csr_if;
   logic                     valid;
   logic                     ready;
   mexp_pkg::csr_index_type  index;
   mexp_pkg::value_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
   modport monitor (input valid, input ready, input index, input data);
endinterface

// ----- rtl/mexp_ctrl.sv -----
// controller state machine sequencing reduction, multiply and square steps
module mexp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mexp_pkg::dp_status_type status,
   output mexp_pkg::dp_cmd_type    cmd
);
   import mexp_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RED_START;
         end
         ST_RED_START: state_in = ST_RED_RUN;
         ST_RED_RUN: begin
            if (status.mul_last) state_in = ST_RED_WB;
         end
         ST_RED_WB: state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = status.exp_bit ? ST_MUL_RUN : ST_SQR_RUN;
         end
         ST_MUL_RUN: begin
            if (status.mul_last) state_in = ST_MUL_WB;
         end
         ST_MUL_WB: state_in = ST_SQR_RUN;
         ST_SQR_RUN: begin
            if (status.mul_last) state_in = ST_SQR_WB;
         end
         ST_SQR_WB: begin
            state_in = status.exp_last ? ST_FINISH : ST_CHECK;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.mul_src = SRC_REDUCE;
      cmd.wb_dest = WB_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RED_START: begin
            cmd.mul_start = 1'b1;
            cmd.mul_src   = SRC_REDUCE;
         end
         ST_RED_RUN, ST_MUL_RUN, ST_SQR_RUN: begin
            cmd.mul_step = 1'b1;
         end
         ST_RED_WB: begin
            cmd.wb_dest = WB_BASE;
         end
         ST_CHECK: begin
            cmd.mul_start = 1'b1;
            cmd.mul_src   = status.exp_bit ? SRC_RESULT : SRC_SQUARE;
         end
         ST_MUL_WB: begin
            cmd.wb_dest   = WB_RESULT;
            cmd.mul_start = 1'b1;
            cmd.mul_src   = SRC_SQUARE;
         end
         ST_SQR_WB: begin
            cmd.wb_dest   = WB_BASE;
            cmd.exp_shift = 1'b1;
         end
         ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/mexp_datapath.sv -----
// registers, bit-serial modular multiplier and result register
module mexp_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  mexp_pkg::csr_index_type csr_index,
   input  mexp_pkg::value_type     csr_data,
   input  logic                    req_cmd,
   input  mexp_pkg::value_type     req_peer_value,
   input  mexp_pkg::value_type     req_exponent,
   input  mexp_pkg::dp_cmd_type    cmd,
   output mexp_pkg::dp_status_type status,
   output mexp_pkg::value_type     key_value
);
   import mexp_pkg::*;

   value_type modulus_ff, generator_ff;
   value_type base_ff, result_ff, exp_ff, key_ff;
   value_type mul_a_ff, mul_b_ff, acc_ff;
   count_type bit_cnt_ff, exp_cnt_ff;

   value_type              mul_a_in;
   value_type              acc_in;
   logic [VALUE_WIDTH:0]   mod_ext, dbl, dbl_red, sum, sum_red;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MODULUS_RESET;
         generator_ff <= GENERATOR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_MODULUS:   modulus_ff   <= csr_data;
            REG_GENERATOR: generator_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // operand select
   always_comb begin
      case (cmd.mul_src)
         SRC_REDUCE: mul_a_in = value_type'(1);
         SRC_RESULT: mul_a_in = result_ff;
         SRC_SQUARE: mul_a_in = base_ff;
         default:    mul_a_in = base_ff;
      endcase
   end

   // one doubling step: acc = 2*acc + bit*a, reduced after each add
   always_comb begin
      mod_ext = {1'b0, modulus_ff};
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
      sum     = dbl_red + (mul_b_ff[VALUE_WIDTH-1] ? {1'b0, mul_a_ff} : '0);
      sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;
      acc_in  = sum_red[VALUE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         mul_a_ff   <= mul_a_in;
         mul_b_ff   <= base_ff;
         acc_ff     <= '0;
         bit_cnt_ff <= '0;
      end else if (cmd.mul_step) begin
         acc_ff     <= acc_in;
         mul_b_ff   <= {mul_b_ff[VALUE_WIDTH-2:0], 1'b0};
         bit_cnt_ff <= bit_cnt_ff + count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff    <= (req_cmd == CMD_SHARED) ? req_peer_value : generator_ff;
         exp_ff     <= req_exponent;
         result_ff  <= value_type'(1);
         exp_cnt_ff <= '0;
      end else begin
         case (cmd.wb_dest)
            WB_BASE:   base_ff   <= acc_ff;
            WB_RESULT: result_ff <= acc_ff;
            default: ;
         endcase
         if (cmd.exp_shift) begin
            exp_ff     <= exp_ff >> 1;
            exp_cnt_ff <= exp_cnt_ff + count_type'(1);
         end
      end
   end

   // modulus below two gives zero
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         key_ff <= (modulus_ff < value_type'(2)) ? '0 : result_ff;
      end
   end

   assign status.mul_last = (bit_cnt_ff == count_type'(VALUE_WIDTH-1));
   assign status.exp_bit  = exp_ff[0];
   assign status.exp_last = (exp_cnt_ff == count_type'(VALUE_WIDTH-1));
   assign key_value       = key_ff;

endmodule

// ----- rtl/modular_exponentiation_key_exchange.sv -----
// top level of the modular exponentiation key exchange block
// Each request returns base^exponent mod modulus, where the base is the generator
// register for a public-key request and peer_value for a shared-key request. One
// request is worked on at a time by the single bit-serial modular multiplier, which
// does one double-and-add step per cycle: 31 steps to reduce the base, then per
// exponent bit one optional multiply and one square of 31 steps each. A finished
// response waits in an output register and the next request can be accepted
// meanwhile. Register writes (modulus index 0, generator index 1) are always ready
// and must only be made while no request is in progress.
module modular_exponentiation_key_exchange (
   input  logic        clock,
   input  logic        reset,
   mexp_req_if.sink    req_chan,
   mexp_rsp_if.source  rsp_chan,
   mexp_csr_if.sink    csr_chan
);
   import mexp_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign csr_chan.ready = 1'b1;

   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   mexp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_chan.valid & csr_chan.ready),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .req_cmd        (req_chan.cmd),
      .req_peer_value (req_chan.peer_value),
      .req_exponent   (req_chan.exponent),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .key_value      (rsp_chan.key_value)
   );

endmodule

// ----- rtl/mexp_checker.sv -----
// port-level assertions for the modular exponentiation block and its bind
module mexp_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  mexp_pkg::value_type rsp_key_value
);

   logic       req_acc, rsp_acc;
   logic [1:0] pending_ff, pending_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + 2'(req_acc) - 2'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_key_value))
      else $error("response payload changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request accepted while previous one in progress");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without outstanding request");

endmodule

bind modular_exponentiation_key_exchange mexp_checker u_mexp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_key_value (rsp_chan.key_value)
);
